// ===== sv/edtc_pkg.sv =====
// Package for the event duplicate track check.
// Holds the track record, status structs, state encodings and register constants.
// Depends on nothing; the window, scan and top-level files import it.
`timescale 1ns / 1ps
`default_nettype none

package edtc_pkg;

  // One stored particle, compared field by field.
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [15:0] sp;
  } track_t;

  // Window test result, valid in the cycle done is high.
  typedef struct packed {
    logic done;
    logic pass;
  } win_result_t;

  // Store scan status: one match strobe per equal entry, done at the end.
  typedef struct packed {
    logic done;
    logic match;
  } scan_status_t;

  typedef enum logic [2:0] {
    W_IDLE,
    W_SQX,
    W_SQY,
    W_SQZ,
    W_LO,
    W_HI,
    W_SUM,
    W_CMP
  } win_state_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WIN,
    S_SCAN,
    S_STORE,
    S_FINISH
  } ctrl_state_t;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_FACTOR = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_BAD_THRESHOLD = 1'b1;

  localparam logic [31:0] WINDOW_FACTOR_RESET = 32'd90513;
  localparam logic [15:0] BAD_THRESHOLD_RESET = 16'd2;

  // Species magnitudes that are always rejected.
  localparam logic [15:0] SPECIES_PI0   = 16'd111;
  localparam logic [15:0] SPECIES_KSTAR = 16'd313;

  localparam logic [15:0] TALLY_MAX = 16'hFFFF;

endpackage : edtc_pkg

`default_nettype wire

// ===== sv/edtc_in_if.sv =====
// Particle request channel: valid/ready handshake with one particle as payload.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface edtc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] mom_x;
  logic signed [31:0] mom_y;
  logic signed [31:0] mom_z;
  logic signed [15:0] species;
  logic               last_particle;

  modport source (
    output valid, mom_x, mom_y, mom_z, species, last_particle,
    input  ready
  );

  modport sink (
    input  valid, mom_x, mom_y, mom_z, species, last_particle,
    output ready
  );
endinterface : edtc_in_if

`default_nettype wire

// ===== sv/edtc_out_if.sv =====
// Result request channel: valid/ready handshake with the event verdict as payload.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface edtc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pair_count;
  logic        bad_event;

  modport source (
    output valid, pair_count, bad_event,
    input  ready
  );

  modport sink (
    input  valid, pair_count, bad_event,
    output ready
  );
endinterface : edtc_out_if

`default_nettype wire

// ===== sv/edtc_window.sv =====
// Pseudorapidity window test: pz^2 * 2^16 <= window_factor * (px^2 + py^2), exact.
// One shared 32x32 multiplier stepped by a small sequencer. Uses edtc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module edtc_window
  import edtc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire track_t      track,
  input  wire logic [31:0] window_factor,
  output win_result_t      res
);

  win_state_t  state, state_next;

  logic [31:0] ax, ay, az;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [63:0] prod;
  logic [63:0] acc;
  logic [63:0] pt2;
  logic [63:0] pz2;
  logic [95:0] rhs;
  logic [95:0] lhs;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? 32'(~v + 32'd1) : v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= W_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_a      = window_factor;
    mul_b      = pt2[31:0];
    unique case (state)
      W_IDLE: begin
        if (start) state_next = W_SQX;
      end
      W_SQX: begin
        mul_a      = ax;
        mul_b      = ax;
        state_next = W_SQY;
      end
      W_SQY: begin
        mul_a      = ay;
        mul_b      = ay;
        state_next = W_SQZ;
      end
      W_SQZ: begin
        mul_a      = az;
        mul_b      = az;
        state_next = W_LO;
      end
      W_LO: begin
        mul_b      = pt2[31:0];
        state_next = W_HI;
      end
      W_HI: begin
        mul_b      = pt2[63:32];
        state_next = W_SUM;
      end
      W_SUM: begin
        state_next = W_CMP;
      end
      W_CMP: begin
        state_next = W_IDLE;
      end
      default: state_next = W_IDLE;
    endcase
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // Datapath: each step registers the product before it is used.
  always_ff @(posedge clk) begin
    prod <= mul_p;
    unique case (state)
      W_IDLE: begin
        if (start) begin
          ax <= mag32(track.x);
          ay <= mag32(track.y);
          az <= mag32(track.z);
        end
      end
      W_SQY:  acc <= prod;
      W_SQZ:  pt2 <= acc + prod;
      W_LO:   pz2 <= prod;
      W_HI:   acc <= prod;
      W_SUM:  rhs <= {prod, 32'd0} + {32'd0, acc};
      default: begin
      end
    endcase
  end

  assign lhs      = {16'd0, pz2, 16'd0};
  assign res.done = (state == W_CMP);
  // Zero transverse momentum is rejected whatever pz is.
  assign res.pass = (pt2 != 64'd0) && (lhs <= rhs);

endmodule : edtc_window

`default_nettype wire

// ===== sv/edtc_scan.sv =====
// Track store and scan: a one-port-read memory of accepted tracks, swept entry by entry
// and compared with the current track. Uses edtc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module edtc_scan
  import edtc_pkg::*;
#(
  parameter int MAX_PARTICLES = 1024
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  input  wire logic                                 wr_en,
  input  wire logic [$clog2(MAX_PARTICLES+1)-1:0]   count,
  input  wire track_t                               track,
  output scan_status_t                              status
);

  localparam int AW = $clog2(MAX_PARTICLES);
  localparam int CW = $clog2(MAX_PARTICLES + 1);

  track_t          mem [MAX_PARTICLES];
  track_t          rd_data;
  logic            active;
  logic            rd_vld;
  logic [CW-1:0]   rd_idx;
  logic            more;

  assign more = (rd_idx != count);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      rd_vld <= 1'b0;
      rd_idx <= '0;
    end else if (start) begin
      active <= 1'b1;
      rd_vld <= 1'b0;
      rd_idx <= '0;
    end else if (active) begin
      rd_vld <= more;
      if (more) begin
        rd_idx <= CW'(rd_idx + 1'b1);
      end else if (!rd_vld) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (active && more) begin
      rd_data <= mem[rd_idx[AW-1:0]];
    end
  end

  // The controller writes only after the sweep and only while the store has room.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[AW-1:0]] <= track;
    end
  end

  assign status.match = rd_vld && (rd_data == track);
  assign status.done  = active && !more && !rd_vld;

endmodule : edtc_scan

`default_nettype wire

// ===== sv/event_duplicate_track_check.sv =====
// Event duplicate track check, top level. Uses edtc_pkg, the channel interfaces and the
// window and scan units. A rejected particle skips the sweep; an accepted one is
// compared with the N tracks already stored (at most MAX_PARTICLES) by sweeping the
// single read port of the track memory one entry per cycle. A last particle waits for
// a free output register, and its result is valid in the next cycle. Reset clears the
// controller, counters and output valid; the memory and data registers are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module event_duplicate_track_check
  import edtc_pkg::*;
#(
  parameter int MAX_PARTICLES = 1024
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  edtc_in_if.sink                     particle,
  edtc_out_if.source                  result,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW = $clog2(MAX_PARTICLES + 1);
  localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_PARTICLES);

  ctrl_state_t   state, state_next;

  logic [31:0]   window_factor;
  logic [15:0]   bad_threshold;

  track_t        item;
  track_t        in_track;
  logic          item_last;
  logic [CW-1:0] stored_count;
  logic [15:0]   pair_tally;

  logic          out_valid;
  logic [15:0]   out_count;
  logic          out_bad;

  logic          take;
  logic          win_start;
  logic          scan_start;
  logic          store_wr;
  logic          out_load;
  logic [15:0]   sp_mag;
  logic          species_ok;

  win_result_t   win_res;
  scan_status_t  scan_st;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_factor <= WINDOW_FACTOR_RESET;
      bad_threshold <= BAD_THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_FACTOR: window_factor <= cfg_data;
        REG_BAD_THRESHOLD: bad_threshold <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  assign particle.ready = (state == S_IDLE);
  assign take           = particle.valid && particle.ready;

  always_ff @(posedge clk) begin
    if (take) begin
      item.x    <= particle.mom_x;
      item.y    <= particle.mom_y;
      item.z    <= particle.mom_z;
      item.sp   <= particle.species;
      item_last <= particle.last_particle;
    end
  end

  // The window unit latches magnitudes in the cycle the request is taken.
  assign in_track = {particle.mom_x, particle.mom_y, particle.mom_z, particle.species};

  assign sp_mag     = item.sp[15] ? 16'(~item.sp + 16'd1) : item.sp;
  assign species_ok = (sp_mag != SPECIES_PI0) && (sp_mag != SPECIES_KSTAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    win_start  = 1'b0;
    scan_start = 1'b0;
    store_wr   = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (take) state_next = S_WIN;
      end
      S_WIN: begin
        win_start = 1'b0;
        if (win_res.done) begin
          if (win_res.pass && species_ok) begin
            scan_start = 1'b1;
            state_next = S_SCAN;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_SCAN: begin
        if (scan_st.done) state_next = S_STORE;
      end
      S_STORE: begin
        // A full store still counts the pairs but keeps no new entry.
        store_wr   = (stored_count < COUNT_MAX);
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!item_last) begin
          state_next = S_IDLE;
        end else if (!out_valid || result.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (take) win_start = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count <= '0;
      pair_tally   <= '0;
    end else if (out_load) begin
      stored_count <= '0;
      pair_tally   <= '0;
    end else begin
      if (store_wr) stored_count <= CW'(stored_count + 1'b1);
      if (scan_st.match && (pair_tally != TALLY_MAX)) pair_tally <= pair_tally + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_count <= pair_tally;
      out_bad   <= (pair_tally >= bad_threshold);
    end
  end

  assign result.valid      = out_valid;
  assign result.pair_count = out_count;
  assign result.bad_event  = out_bad;

  edtc_window u_window (
    .clk           (clk),
    .rst           (rst),
    .start         (win_start),
    .track         (in_track),
    .window_factor (window_factor),
    .res           (win_res)
  );

  edtc_scan #(
    .MAX_PARTICLES (MAX_PARTICLES)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .start  (scan_start),
    .wr_en  (store_wr),
    .count  (stored_count),
    .track  (item),
    .status (scan_st)
  );

  a_match_only_in_scan: assert property (
    @(posedge clk) disable iff (rst) scan_st.match |-> (state == S_SCAN)
  ) else $error("store match strobe outside the scan");

  a_window_done_in_win: assert property (
    @(posedge clk) disable iff (rst) win_res.done |-> (state == S_WIN)
  ) else $error("window result outside the window wait");

  a_count_bounded: assert property (
    @(posedge clk) disable iff (rst) store_wr |=> (stored_count <= COUNT_MAX)
  ) else $error("stored count beyond capacity");

  a_event_cleared: assert property (
    @(posedge clk) disable iff (rst)
      out_load |=> (stored_count == '0) && (pair_tally == '0) && out_valid
  ) else $error("event state not cleared after result");

endmodule : event_duplicate_track_check

`default_nettype wire
